### rtl/scmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scmd_pkg;

    // sample and delay memory geometry
    localparam int SAMPLE_W  = 24;
    localparam int DLY_AW    = 11;
    localparam int DLY_DEPTH = 1 << DLY_AW;
    localparam int FILL_W    = DLY_AW + 1;

    // LFO and delay arithmetic
    localparam int PHASE_W    = 32;
    localparam int PHASE_FRAC = 30;
    localparam int STEP_W     = 31;
    localparam int SQ_W       = 2 * PHASE_W - PHASE_FRAC;
    localparam int SHAPE_W    = PHASE_FRAC + 1;
    localparam int MOD_W      = 27;
    localparam int DLY_W      = MOD_W + 1;
    localparam int FRAC_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int SAT_IN_W   = 32;

    // configuration port
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 3;

    localparam logic [GAIN_W-1:0] WET_GAIN_RST = 16'd15401;
    localparam logic [GAIN_W-1:0] DRY_GAIN_RST = 16'd17367;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP,
        CFG_MOD_DEPTH,
        CFG_MOD_OFFSET,
        CFG_WET_GAIN,
        CFG_DRY_GAIN,
        CFG_FEEDBACK_GAIN
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PHASE,
        S_SQUARE,
        S_DEPTH,
        S_RD0,
        S_RD1,
        S_INTERP,
        S_TAP,
        S_MIX,
        S_OUT
    } state_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
    } in_frame_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } out_frame_t;

    typedef struct packed {
        logic [STEP_W-1:0]        phase_step;
        logic [MOD_W-1:0]         mod_depth;
        logic [MOD_W-1:0]         mod_offset;
        logic [GAIN_W-1:0]        wet_gain;
        logic [GAIN_W-1:0]        dry_gain;
        logic signed [GAIN_W-1:0] feedback_gain;
    } cfg_t;

    typedef struct packed {
        logic adv;
        logic sq_en;
        logic dep_en;
    } lfo_ctrl_t;

    typedef struct packed {
        logic fb_en;
        logic wr_en;
        logic rd_en;
        logic t0_en;
        logic t0_valid;
        logic ip_en;
        logic t1_valid;
        logic tap_en;
        logic mix_en;
    } chan_ctrl_t;

    // clamp to the signed sample range
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [SAT_IN_W-1:0] x
    );
        logic signed [SAT_IN_W-1:0] hi;
        logic signed [SAT_IN_W-1:0] lo;
        hi = {{(SAT_IN_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
        lo = {{(SAT_IN_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};
        if (x > hi)
        begin
            return hi[SAMPLE_W-1:0];
        end
        else if (x < lo)
        begin
            return lo[SAMPLE_W-1:0];
        end
        return x[SAMPLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/scmd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module scmd_ram #(
    parameter int ADDR_W = 11,
    parameter int DATA_W = 24
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [1 << ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/scmd_lfo.sv
`timescale 1ns / 1ps
`default_nettype none

module scmd_lfo (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire scmd_pkg::cfg_t             cfg,
    input  wire scmd_pkg::lfo_ctrl_t        ctrl,
    output logic [scmd_pkg::DLY_W-1:0]      dly
);

    import scmd_pkg::*;

    localparam logic signed [PHASE_W+1:0] PH_ONE =
        {{(PHASE_W+1-PHASE_FRAC){1'b0}}, 1'b1, {PHASE_FRAC{1'b0}}};
    localparam logic signed [PHASE_W+1:0] PH_TWO =
        {{(PHASE_W-PHASE_FRAC){1'b0}}, 1'b1, {(PHASE_FRAC+1){1'b0}}};
    localparam logic [SQ_W-1:0] SQ_ONE =
        {{(SQ_W-PHASE_FRAC-1){1'b0}}, 1'b1, {PHASE_FRAC{1'b0}}};
    localparam logic [SHAPE_W-1:0] SHAPE_ONE = {1'b1, {PHASE_FRAC{1'b0}}};

    logic signed [PHASE_W-1:0]   phase_reg;
    logic [SQ_W-1:0]             sq_reg;
    logic [MOD_W-1:0]            dprod_reg;

    logic signed [PHASE_W+1:0]   sum;
    logic signed [PHASE_W+1:0]   wrapped;
    logic [PHASE_W-1:0]          mag;
    logic [2*PHASE_W-1:0]        sq_full;
    logic [SHAPE_W-1:0]          shape;
    logic [MOD_W+SHAPE_W-1:0]    dprod_full;

    // phase step, wrap by two once past +1.0
    always_comb
    begin
        sum = {{2{phase_reg[PHASE_W-1]}}, phase_reg}
            + {{(PHASE_W+2-STEP_W){1'b0}}, cfg.phase_step};
        wrapped = (sum > PH_ONE) ? (sum - PH_TWO) : sum;
    end

    // 1 - phase^2, floored at zero
    always_comb
    begin
        mag     = phase_reg[PHASE_W-1] ? (~phase_reg + 1'b1) : phase_reg;
        sq_full = mag * mag;
        if (sq_reg >= SQ_ONE)
        begin
            shape = '0;
        end
        else
        begin
            shape = SHAPE_ONE - sq_reg[SHAPE_W-1:0];
        end
        dprod_full = cfg.mod_depth * shape;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (ctrl.adv)
        begin
            phase_reg <= wrapped[PHASE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sq_en)
        begin
            sq_reg <= sq_full[2*PHASE_W-1:PHASE_FRAC];
        end
        if (ctrl.dep_en)
        begin
            dprod_reg <= dprod_full[MOD_W+PHASE_FRAC-1:PHASE_FRAC];
        end
    end

    assign dly = {1'b0, cfg.mod_offset} + {1'b0, dprod_reg};

endmodule

`default_nettype wire

### rtl/scmd_chan.sv
`timescale 1ns / 1ps
`default_nettype none

module scmd_chan (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire scmd_pkg::cfg_t                    cfg,
    input  wire scmd_pkg::chan_ctrl_t              ctrl,
    input  wire logic signed [scmd_pkg::SAMPLE_W-1:0] sample,
    input  wire logic [scmd_pkg::DLY_AW-1:0]       wr_addr,
    input  wire logic [scmd_pkg::DLY_AW-1:0]       rd_addr,
    input  wire logic [scmd_pkg::FRAC_W-1:0]       frac,
    output logic signed [scmd_pkg::SAMPLE_W-1:0]   res
);

    import scmd_pkg::*;

    localparam int FBP_W = GAIN_W + SAMPLE_W;
    localparam int WS_W  = SAMPLE_W + 2;
    localparam int DF_W  = SAMPLE_W + 1;
    localparam int IP_W  = FRAC_W + 1 + DF_W;
    localparam int MP_W  = SAMPLE_W + GAIN_W + 1;
    localparam int MX_W  = MP_W + 1;
    localparam int MS_W  = MX_W - (GAIN_W - 1);

    logic signed [FBP_W-1:0]    fbp_reg;
    logic signed [SAMPLE_W-1:0] t0_reg;
    logic signed [IP_W-1:0]     ip_reg;
    logic signed [SAMPLE_W-1:0] last_tap_reg;
    logic signed [MP_W-1:0]     dryp_reg;
    logic signed [MP_W-1:0]     wetp_reg;

    logic signed [FBP_W-1:0]    fb_prod;
    logic signed [WS_W-1:0]     wsum;
    logic signed [SAMPLE_W-1:0] wdata;
    logic [SAMPLE_W-1:0]        rdata;
    logic signed [SAMPLE_W-1:0] t1;
    logic signed [DF_W-1:0]     diff;
    logic signed [IP_W-1:0]     ip_full;
    logic signed [WS_W-1:0]     tap_sum;
    logic signed [MP_W-1:0]     dryp;
    logic signed [MP_W-1:0]     wetp;
    logic signed [MX_W-1:0]     mix;

    // write path: input plus scaled previous tap
    always_comb
    begin
        fb_prod = cfg.feedback_gain * last_tap_reg;
        wsum    = {{2{sample[SAMPLE_W-1]}}, sample}
                + {fbp_reg[FBP_W-1], fbp_reg[FBP_W-1:GAIN_W-1]};
        wdata   = sat_sample({{(SAT_IN_W-WS_W){wsum[WS_W-1]}}, wsum});
    end

    scmd_ram #(
        .ADDR_W (DLY_AW),
        .DATA_W (SAMPLE_W)
    ) u_ram (
        .clk   (clk),
        .we    (ctrl.wr_en),
        .waddr (wr_addr),
        .wdata (wdata),
        .re    (ctrl.rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // linear interpolation; unwritten entries read as zero
    always_comb
    begin
        t1      = ctrl.t1_valid ? rdata : '0;
        diff    = {t1[SAMPLE_W-1], t1} - {t0_reg[SAMPLE_W-1], t0_reg};
        ip_full = $signed({1'b0, frac}) * diff;
        tap_sum = {{2{t0_reg[SAMPLE_W-1]}}, t0_reg} + ip_reg[IP_W-1:FRAC_W];
    end

    // dry minus wet
    always_comb
    begin
        dryp = sample * $signed({1'b0, cfg.dry_gain});
        wetp = last_tap_reg * $signed({1'b0, cfg.wet_gain});
        mix  = {dryp_reg[MP_W-1], dryp_reg} - {wetp_reg[MP_W-1], wetp_reg};
        res  = sat_sample({{(SAT_IN_W-MS_W){mix[MX_W-1]}}, mix[MX_W-1:GAIN_W-1]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_tap_reg <= '0;
        end
        else if (ctrl.tap_en)
        begin
            last_tap_reg <= tap_sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fb_en)
        begin
            fbp_reg <= fb_prod;
        end
        if (ctrl.t0_en)
        begin
            t0_reg <= ctrl.t0_valid ? rdata : '0;
        end
        if (ctrl.ip_en)
        begin
            ip_reg <= ip_full;
        end
        if (ctrl.mix_en)
        begin
            dryp_reg <= dryp;
            wetp_reg <= wetp;
        end
    end

endmodule

`default_nettype wire

### rtl/stereo_chorus_modulated_delay.sv
`timescale 1ns / 1ps
`default_nettype none

// Stereo chorus: one stereo frame in, one processed frame out, per transfer.
// The input stalls while a frame is in flight; the result sits in an output
// register, so a new frame is taken while it waits. The frame sequencer walks
// each frame through the shared LFO multipliers (phase square, depth scaling)
// and through the delay memories: each channel has one 2048 x 24 memory with
// one write and one read port, and a frame needs one write and two
// interpolation reads on it. The write lands before the reads, so a delay of
// zero returns the sample just written. Memories are not cleared: a fill
// count tracks how many entries have been written since reset and reads
// beyond it return zero, so no clearing pass runs and the block is ready
// straight out of reset. Configuration writes go in through a plain write
// port (index 0..5 in register order, others ignored) and should only happen
// while no frame is in flight.
module stereo_chorus_modulated_delay (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire scmd_pkg::in_frame_t                 in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output scmd_pkg::out_frame_t                     out_data,
    input  wire logic                                cfg_we,
    input  wire logic [scmd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [scmd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import scmd_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    cfg_t                cfg_reg;
    in_frame_t           in_reg;
    out_frame_t          out_reg;
    logic                out_valid_reg;
    logic [DLY_AW-1:0]   wp_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [DLY_AW-1:0]   k_reg;
    logic [FRAC_W-1:0]   frac_reg;
    logic                v0_reg;
    logic                v1_reg;

    logic                in_xfer;
    logic                out_free;
    logic                out_load;
    logic                addr_load;
    logic                v1_load;
    lfo_ctrl_t           lfo_ctrl;
    chan_ctrl_t          chan_ctrl;
    logic [DLY_W-1:0]    dly;
    logic [DLY_AW-1:0]   k;
    logic [DLY_AW-1:0]   k1;
    logic [DLY_AW-1:0]   rd_addr;
    logic signed [SAMPLE_W-1:0] left_res;
    logic signed [SAMPLE_W-1:0] right_res;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // integer delay, taken modulo the memory depth
    assign k  = dly[DLY_AW+FRAC_W-1:FRAC_W];
    assign k1 = k_reg + 1'b1;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step    <= '0;
            cfg_reg.mod_depth     <= '0;
            cfg_reg.mod_offset    <= '0;
            cfg_reg.wet_gain      <= WET_GAIN_RST;
            cfg_reg.dry_gain      <= DRY_GAIN_RST;
            cfg_reg.feedback_gain <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PHASE_STEP:    cfg_reg.phase_step    <= cfg_data[STEP_W-1:0];
                CFG_MOD_DEPTH:     cfg_reg.mod_depth     <= cfg_data[MOD_W-1:0];
                CFG_MOD_OFFSET:    cfg_reg.mod_offset    <= cfg_data[MOD_W-1:0];
                CFG_WET_GAIN:      cfg_reg.wet_gain      <= cfg_data[GAIN_W-1:0];
                CFG_DRY_GAIN:      cfg_reg.dry_gain      <= cfg_data[GAIN_W-1:0];
                CFG_FEEDBACK_GAIN: cfg_reg.feedback_gain <= cfg_data[GAIN_W-1:0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------ sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   state_next = in_xfer ? S_PHASE : S_IDLE;
            S_PHASE:  state_next = S_SQUARE;
            S_SQUARE: state_next = S_DEPTH;
            S_DEPTH:  state_next = S_RD0;
            S_RD0:    state_next = S_RD1;
            S_RD1:    state_next = S_INTERP;
            S_INTERP: state_next = S_TAP;
            S_TAP:    state_next = S_MIX;
            S_MIX:    state_next = S_OUT;
            S_OUT:    state_next = out_free ? S_IDLE : S_OUT;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        lfo_ctrl  = '0;
        chan_ctrl = '0;
        rd_addr   = wp_reg + k;
        addr_load = 1'b0;
        v1_load   = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            S_PHASE:
            begin
                lfo_ctrl.adv    = 1'b1;
                chan_ctrl.fb_en = 1'b1;
            end
            S_SQUARE:
            begin
                lfo_ctrl.sq_en  = 1'b1;
                chan_ctrl.wr_en = 1'b1;
            end
            S_DEPTH:
            begin
                lfo_ctrl.dep_en = 1'b1;
            end
            S_RD0:
            begin
                chan_ctrl.rd_en = 1'b1;
                addr_load       = 1'b1;
            end
            S_RD1:
            begin
                chan_ctrl.rd_en    = 1'b1;
                chan_ctrl.t0_en    = 1'b1;
                chan_ctrl.t0_valid = v0_reg;
                rd_addr            = wp_reg + k1;
                v1_load            = 1'b1;
            end
            S_INTERP:
            begin
                chan_ctrl.ip_en    = 1'b1;
                chan_ctrl.t1_valid = v1_reg;
            end
            S_TAP:
            begin
                chan_ctrl.tap_en = 1'b1;
            end
            S_MIX:
            begin
                chan_ctrl.mix_en = 1'b1;
            end
            S_OUT:
            begin
                out_load = out_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // write position walks backwards; fill count saturates at the depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_PHASE)
            begin
                wp_reg <= wp_reg - 1'b1;
                if (fill_reg != FILL_W'(DLY_DEPTH))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_reg <= in_data;
        end
        if (addr_load)
        begin
            k_reg    <= k;
            frac_reg <= dly[FRAC_W-1:0];
            v0_reg   <= ({1'b0, k} < fill_reg);
        end
        if (v1_load)
        begin
            v1_reg <= ({1'b0, k1} < fill_reg);
        end
        if (out_load)
        begin
            out_reg.left_out  <= left_res;
            out_reg.right_out <= right_res;
        end
    end

    // ------------------------------------------------------------- datapath
    scmd_lfo u_lfo (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .ctrl  (lfo_ctrl),
        .dly   (dly)
    );

    scmd_chan u_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .ctrl    (chan_ctrl),
        .sample  (in_reg.left_in),
        .wr_addr (wp_reg),
        .rd_addr (rd_addr),
        .frac    (frac_reg),
        .res     (left_res)
    );

    scmd_chan u_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .ctrl    (chan_ctrl),
        .sample  (in_reg.right_in),
        .wr_addr (wp_reg),
        .rd_addr (rd_addr),
        .frac    (frac_reg),
        .res     (right_res)
    );

`ifndef SYNTHESIS
    a_xfer_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_PHASE)
        else $error("input transfer did not start a frame");

    a_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PHASE |=> wp_reg == $past(wp_reg) - 1'b1)
        else $error("write position did not step back by one");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(DLY_DEPTH))
        else $error("fill count beyond memory depth");

    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && out_free |=> out_valid_reg && state_reg == S_IDLE)
        else $error("finished frame not presented");
`endif

endmodule

`default_nettype wire

### sim/stereo_chorus_modulated_delay_tb.sv
`timescale 1ns / 1ps

module stereo_chorus_modulated_delay_tb;

    import scmd_pkg::*;

    // ---------------------------------------------------------------------
    // Constants
    // ---------------------------------------------------------------------
    localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam longint PHASE_ONE  = longint'(1) << PHASE_FRAC;
    localparam longint FRAC_MASK  = (longint'(1) << FRAC_W) - 1;
    localparam int     DLY_MASK   = DLY_DEPTH - 1;
    localparam int     NUM_REGS   = 6;

    // indexes beyond the register list; the block must drop these writes
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_HI = 3'd7;

    localparam int RAND_PHASES     = 12;
    localparam int ITEMS_PER_PHASE = 158;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int SETTLE_CYCLES   = 30;

    // ---------------------------------------------------------------------
    // Clock, reset and block ports
    // ---------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_frame_t             in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_frame_t            out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    stereo_chorus_modulated_delay u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ---------------------------------------------------------------------
    // Chorus predictor: own copy of the delay lines, LFO and registers
    // ---------------------------------------------------------------------
    longint left_line  [DLY_DEPTH];
    longint right_line [DLY_DEPTH];
    int     wr_pos         = 0;
    longint lfo_acc        = 0;
    longint left_prev_tap  = 0;
    longint right_prev_tap = 0;
    cfg_t   model_cfg;

    // frames predicted but not yet seen at the output, oldest first
    out_frame_t pending_frames [$];

    int  mismatches   = 0;
    int  frames_seen  = 0;
    bit  gaps_on      = 1'b1;
    int  stall_left   = 0;
    int  idle_cycles  = 0;

    function automatic longint clamp_sample(input longint x);
        if (x > SAMPLE_MAX)
        begin
            return SAMPLE_MAX;
        end
        if (x < SAMPLE_MIN)
        begin
            return SAMPLE_MIN;
        end
        return x;
    endfunction

    // one channel: feedback write, interpolated tap, dry/wet mix
    function automatic longint mix_channel(input bit right_ch, input longint sample,
                                           input int wp, input int ip, input longint frac);
        longint prev;
        longint fb;
        longint wet;
        longint dry;
        longint t0;
        longint t1;
        longint tap;
        prev = right_ch ? right_prev_tap : left_prev_tap;
        fb   = $signed(model_cfg.feedback_gain);
        wet  = model_cfg.wet_gain;
        dry  = model_cfg.dry_gain;
        // write lands before the reads, so a zero delay sees this sample
        if (right_ch)
        begin
            right_line[wp] = clamp_sample(sample + ((fb * prev) >>> 15));
            t0 = right_line[ip];
            t1 = right_line[(ip + 1) & DLY_MASK];
        end
        else
        begin
            left_line[wp] = clamp_sample(sample + ((fb * prev) >>> 15));
            t0 = left_line[ip];
            t1 = left_line[(ip + 1) & DLY_MASK];
        end
        tap = t0 + ((frac * (t1 - t0)) >>> FRAC_W);
        if (right_ch)
        begin
            right_prev_tap = tap;
        end
        else
        begin
            left_prev_tap = tap;
        end
        return clamp_sample((sample * dry - tap * wet) >>> 15);
    endfunction

    function automatic out_frame_t chorus_step(input in_frame_t frame);
        longint            sum;
        longint            step_v;
        longint unsigned   mag;
        longint unsigned   sq;
        longint unsigned   shape;
        longint unsigned   depth_v;
        longint unsigned   dly;
        int                ip;
        longint            frac;
        out_frame_t        res;
        step_v = model_cfg.phase_step;
        sum    = lfo_acc + step_v;
        // exactly +1.0 is kept; only beyond it does the phase wrap
        if (sum > PHASE_ONE)
        begin
            sum = sum - 2 * PHASE_ONE;
        end
        lfo_acc = $signed(sum[PHASE_W-1:0]);
        mag     = (lfo_acc < 0) ? -lfo_acc : lfo_acc;
        sq      = (mag * mag) >> PHASE_FRAC;
        // a phase outside [-1,1] squares past 1.0: shape bottoms out at zero
        shape   = (sq >= PHASE_ONE) ? 0 : PHASE_ONE - sq;
        depth_v = model_cfg.mod_depth;
        dly     = model_cfg.mod_offset + ((depth_v * shape) >> PHASE_FRAC);
        wr_pos  = (wr_pos - 1) & DLY_MASK;
        ip      = int'((dly >> FRAC_W) + wr_pos) & DLY_MASK;  // long delays wrap here
        frac    = longint'(dly) & FRAC_MASK;
        res.left_out  = mix_channel(1'b0, frame.left_in,  wr_pos, ip, frac);
        res.right_out = mix_channel(1'b1, frame.right_in, wr_pos, ip, frac);
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Result checking, receiver stalls and watchdog
    // ---------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at frame %0d: %0s got %0d expected %0d",
                 frames_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        out_frame_t want;
        // output transfer: compare against the oldest prediction
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_frames.size() == 0)
            begin
                report_mismatch("unexpected frame, left", out_data.left_out, 0);
            end
            else
            begin
                want = pending_frames.pop_front();
                if (out_data.left_out !== want.left_out)
                begin
                    report_mismatch("left_out", out_data.left_out, want.left_out);
                end
                if (out_data.right_out !== want.right_out)
                begin
                    report_mismatch("right_out", out_data.right_out, want.right_out);
                end
            end
            frames_seen <= frames_seen + 1;
        end

        // receiver back-pressure in bursts of random length
        if (stall_left > 0 && gaps_on)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 9);
        end
        else
        begin
            out_stall <= 1'b0;
        end

        // watchdog: counts cycles with neither an input nor an output transfer nor a register write
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------------

    // offer one frame, hold it until the transfer, then predict it
    task automatic push_frame(input in_frame_t frame, input bit typed, input out_frame_t want);
        out_frame_t predicted;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= frame;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        // state must advance even where the expected frame is typed in
        predicted = chorus_step(frame);
        pending_frames.push_back(typed ? want : predicted);
    endtask

    // stop offering and wait for every predicted frame to come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_frames.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // drive one register write; it lands at the next edge
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_PHASE_STEP:    model_cfg.phase_step    = val[STEP_W-1:0];
            CFG_MOD_DEPTH:     model_cfg.mod_depth     = val[MOD_W-1:0];
            CFG_MOD_OFFSET:    model_cfg.mod_offset    = val[MOD_W-1:0];
            CFG_WET_GAIN:      model_cfg.wet_gain      = val[GAIN_W-1:0];
            CFG_DRY_GAIN:      model_cfg.dry_gain      = val[GAIN_W-1:0];
            CFG_FEEDBACK_GAIN: model_cfg.feedback_gain = val[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    // load a full setting with the block idle, after a write to an unused index; order is
    // rotated at random and the unused upper data bits carry noise so truncation is exercised
    task automatic load_settings(input cfg_t target);
        int                    first;
        int                    k;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        drain();
        cfg_write(($urandom_range(0, 1) != 0) ? CFG_NONE_LO : CFG_NONE_HI, $urandom);
        first = $urandom_range(0, NUM_REGS - 1);
        for (k = 0; k < NUM_REGS; k++)
        begin
            idx = (first + k) % NUM_REGS;
            val = $urandom;
            case (idx)
                CFG_PHASE_STEP:    val[STEP_W-1:0] = target.phase_step;
                CFG_MOD_DEPTH:     val[MOD_W-1:0]  = target.mod_depth;
                CFG_MOD_OFFSET:    val[MOD_W-1:0]  = target.mod_offset;
                CFG_WET_GAIN:      val[GAIN_W-1:0] = target.wet_gain;
                CFG_DRY_GAIN:      val[GAIN_W-1:0] = target.dry_gain;
                default:           val[GAIN_W-1:0] = target.feedback_gain;
            endcase
            cfg_write(idx, val);
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic cfg_t make_cfg(input longint step, input longint depth,
                                      input longint offset, input longint wet,
                                      input longint dry, input longint fb);
        cfg_t c;
        c.phase_step    = step;
        c.mod_depth     = depth;
        c.mod_offset    = offset;
        c.wet_gain      = wet;
        c.dry_gain      = dry;
        c.feedback_gain = fb;
        return c;
    endfunction

    // random setting with the extremes of each register well represented
    function automatic cfg_t rand_settings();
        cfg_t c;
        case ($urandom_range(0, 4))
            0:       c.phase_step = '0;
            1:       c.phase_step = PHASE_ONE;
            2:       c.phase_step = '1;
            3:       c.phase_step = $urandom_range(0, 1 << 22);
            default: c.phase_step = $urandom;
        endcase
        case ($urandom_range(0, 3))
            0:       c.mod_depth = '0;
            1:       c.mod_depth = '1;
            2:       c.mod_depth = $urandom_range(0, 40 << FRAC_W);
            default: c.mod_depth = $urandom;
        endcase
        case ($urandom_range(0, 3))
            0:       c.mod_offset = '0;
            1:       c.mod_offset = '1;
            2:       c.mod_offset = $urandom_range(0, 40 << FRAC_W);
            default: c.mod_offset = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0:       c.wet_gain = '0;
            1:       c.wet_gain = 16'h8000;
            2:       c.wet_gain = '1;
            3:       c.wet_gain = $urandom_range(0, 32768);
            default: c.wet_gain = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0:       c.dry_gain = '0;
            1:       c.dry_gain = 16'h8000;
            2:       c.dry_gain = '1;
            3:       c.dry_gain = $urandom_range(0, 32768);
            default: c.dry_gain = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0:       c.feedback_gain = '0;
            1:       c.feedback_gain = 16'sh7FFF;
            2:       c.feedback_gain = 16'sh8000;
            3:       c.feedback_gain = $urandom_range(0, 16384);
            default: c.feedback_gain = $urandom;
        endcase
        return c;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return $signed($urandom_range(0, 2000)) - 1000;
            default: return $urandom;
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Directed table
    // ---------------------------------------------------------------------
    typedef struct packed {
        logic [3:0] set_id;
        in_frame_t  frame;
        logic       typed;
        out_frame_t want;
    } stim_row_t;

    stim_row_t stim_table [$];
    cfg_t      dir_settings [5];

    task automatic add_row(input int set_id, input longint l, input longint r,
                           input bit typed, input longint wl, input longint wr);
        stim_row_t row;
        row.set_id          = set_id;
        row.frame.left_in   = l;
        row.frame.right_in  = r;
        row.typed           = typed;
        row.want.left_out   = wl;
        row.want.right_out  = wr;
        stim_table.push_back(row);
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial
    begin
        int        cur_set;
        int        ph;
        int        i;
        int        pause_at;
        in_frame_t frame;
        out_frame_t none;

        none = '0;
        model_cfg = make_cfg(0, 0, 0, WET_GAIN_RST, DRY_GAIN_RST, 0);

        // 0: reset values, zero delay: out = floor(in * 1966 / 2^15)
        // 1: phase steps onto exactly +1.0, full depth, unity gains, top feedback
        // 2: step above 1.0, longest offset wrapping the line, gains above 1.0,
        //    most negative feedback
        // 3: all gains zero: output reads zero whatever goes in
        // 4: fractional tap with dry path off
        dir_settings[0] = model_cfg;
        dir_settings[1] = make_cfg(PHASE_ONE, (1 << MOD_W) - 1, 0, 32768, 32768, 32767);
        dir_settings[2] = make_cfg((1 << STEP_W) - 1, 24'h300000, (1 << MOD_W) - 1,
                                   65535, 65535, -32768);
        dir_settings[3] = make_cfg(0, 0, 0, 0, 0, 0);
        dir_settings[4] = make_cfg(32'h1234567, 3 << FRAC_W, (5 << FRAC_W) | 16'h8000,
                                   32768, 0, 16384);

        add_row(0, 0, 0, 1, 0, 0);
        add_row(0, SAMPLE_MAX, SAMPLE_MIN, 1, 503295, -503296);
        add_row(0, SAMPLE_MIN, SAMPLE_MAX, 1, -503296, 503295);
        add_row(0, 1, -1, 1, 0, -1);
        add_row(1, SAMPLE_MAX, SAMPLE_MAX, 0, 0, 0);
        add_row(1, SAMPLE_MIN, SAMPLE_MIN, 0, 0, 0);
        add_row(1, SAMPLE_MAX, SAMPLE_MIN, 0, 0, 0);
        add_row(1, 0, 0, 0, 0, 0);
        add_row(1, 12345, -54321, 0, 0, 0);
        add_row(2, SAMPLE_MAX, SAMPLE_MAX, 0, 0, 0);
        add_row(2, SAMPLE_MIN, SAMPLE_MIN, 0, 0, 0);
        add_row(2, SAMPLE_MIN, SAMPLE_MAX, 0, 0, 0);
        add_row(2, 0, 0, 0, 0, 0);
        add_row(2, -777777, 4444444, 0, 0, 0);
        add_row(3, SAMPLE_MAX, SAMPLE_MIN, 1, 0, 0);
        add_row(3, SAMPLE_MIN, SAMPLE_MAX, 1, 0, 0);
        add_row(3, 24'sh155555, -24'sh2AAAAA, 1, 0, 0);
        add_row(4, SAMPLE_MAX, SAMPLE_MIN, 0, 0, 0);
        add_row(4, 1000000, -1000000, 0, 0, 0);
        add_row(4, SAMPLE_MIN, 0, 0, 0, 0);
        add_row(4, -3, SAMPLE_MAX, 0, 0, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed walk; settings change only between groups, block drained
        cur_set = 0;
        foreach (stim_table[k])
        begin
            if (stim_table[k].set_id != cur_set)
            begin
                cur_set = stim_table[k].set_id;
                load_settings(dir_settings[cur_set]);
            end
            push_frame(stim_table[k].frame, stim_table[k].typed, stim_table[k].want);
        end

        // random phases, each under a fresh setting; the last one runs flat out
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            load_settings(rand_settings());
            gaps_on  = (ph != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
            pause_at = $urandom_range(0, ITEMS_PER_PHASE - 1);
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // sender holds off until the pipeline has emptied
                if (i == pause_at)
                begin
                    drain();
                end
                frame.left_in  = rand_sample();
                frame.right_in = rand_sample();
                push_frame(frame, 1'b0, none);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
